// File: hw/rtl/indexed_linked_list_manager_unit_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the indexed linked list manager
// ---------------------------------------------------------------------------
`ifndef INDEXED_LINKED_LIST_MANAGER_UNIT_MACROS_SVH
`define INDEXED_LINKED_LIST_MANAGER_UNIT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define ILM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define ILM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/ilm_pkg.sv
// ---------------------------------------------------------------------------
// ilm_pkg
// shared types and constants of the indexed linked list manager
// ---------------------------------------------------------------------------
`default_nettype none

package ilm_pkg;

   localparam int FIELD_W        = 10;
   localparam int DEF_NODE_SLOTS = 1024;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_IGNORED  = 2'd1,
      ST_LINKED   = 2'd2,
      ST_UNLINKED = 2'd3
   } status_type;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      S_WIPE,
      S_IDLE,
      S_CHECK,
      S_UNLINK
   } ctrl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       capture;
      logic       wipe;
      logic       link;
      logic       splice;
      logic       detach;
      logic       respond;
      status_type code;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic idx_ok;
      logic remove;
      logic member;
      logic wipe_last;
   } dp_flags_type;

endpackage

`default_nettype wire

// File: hw/rtl/ilm_controller.sv
// ---------------------------------------------------------------------------
// ilm_controller
// sequences the clearing pass and the read, check and write steps of a word
// ---------------------------------------------------------------------------
`default_nettype none

module ilm_controller
   import ilm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire dp_flags_type flags,
   output dp_cmd_type        cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WIPE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.code = ST_DONE;
      busy     = 1'b1;
      unique case (state_ff)
         S_WIPE: begin
            cmd.wipe = 1'b1;
            if (flags.wipe_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (!flags.idx_ok) begin
               cmd.respond = 1'b1;
               cmd.code    = ST_IGNORED;
               state_in    = S_IDLE;
            end else if (!flags.remove) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
               if (flags.member) begin
                  cmd.code = ST_LINKED;
               end else begin
                  cmd.link = 1'b1;
               end
            end else if (!flags.member) begin
               cmd.respond = 1'b1;
               cmd.code    = ST_UNLINKED;
               state_in    = S_IDLE;
            end else begin
               cmd.splice = 1'b1;
               state_in   = S_UNLINK;
            end
         end
         S_UNLINK: begin
            cmd.detach  = 1'b1;
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_WIPE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/ilm_datapath.sv
// ---------------------------------------------------------------------------
// ilm_datapath
// pointer stores, head and count registers and the result register
// ---------------------------------------------------------------------------
`default_nettype none

module ilm_datapath
   import ilm_pkg::*;
#(
   parameter int NODE_SLOTS = DEF_NODE_SLOTS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_cmd_type         cmd,
   output dp_flags_type            flags,
   input  wire logic               req_kind,
   input  wire logic [FIELD_W-1:0] req_node_index,
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_status,
   output logic [FIELD_W-1:0]      rsp_member_count,
   output logic [FIELD_W-1:0]      rsp_head_index
);

   localparam int ADDR_W = $clog2(NODE_SLOTS);

   logic [FIELD_W-1:0] next_mem [NODE_SLOTS];
   logic [FIELD_W-1:0] prev_mem [NODE_SLOTS];

   logic [FIELD_W-1:0] next_rd_ff;
   logic [FIELD_W-1:0] prev_rd_ff;
   logic [FIELD_W-1:0] idx_ff;
   logic               idx_ok_ff;
   logic               remove_ff;
   logic [ADDR_W-1:0]  wipe_ff;
   logic [FIELD_W-1:0] head_ff;
   logic [FIELD_W-1:0] head_in;
   logic [FIELD_W-1:0] count_ff;
   logic [FIELD_W-1:0] count_in;
   logic               rsp_strobe_ff;
   status_type         rsp_status_ff;
   logic [FIELD_W-1:0] rsp_count_ff;
   logic [FIELD_W-1:0] rsp_head_ff;

   logic               req_ok;
   logic [ADDR_W-1:0]  rd_addr;
   logic               next_we;
   logic [ADDR_W-1:0]  next_wa;
   logic [FIELD_W-1:0] next_wd;
   logic               prev_we;
   logic [ADDR_W-1:0]  prev_wa;
   logic [FIELD_W-1:0] prev_wd;

   // out-of-range indexes read entry zero, their result is ignored anyway
   assign req_ok  = (req_node_index != '0) && (32'(req_node_index) < NODE_SLOTS);
   assign rd_addr = req_ok ? ADDR_W'(req_node_index) : '0;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         next_rd_ff <= next_mem[rd_addr];
         prev_rd_ff <= prev_mem[rd_addr];
         idx_ff     <= req_node_index;
         idx_ok_ff  <= req_ok;
         remove_ff  <= (req_kind == KIND_REMOVE);
      end
   end

   // write port selection: before is prev_rd_ff, after is next_rd_ff
   always_comb begin
      next_we = 1'b1;
      next_wa = '0;
      next_wd = '0;
      prev_we = 1'b1;
      prev_wa = '0;
      prev_wd = '0;
      priority if (cmd.wipe) begin
         next_wa = wipe_ff;
         prev_wa = wipe_ff;
      end else if (cmd.link) begin
         next_wa = ADDR_W'(idx_ff);
         next_wd = head_ff;
         prev_wa = ADDR_W'(head_ff);
         prev_wd = idx_ff;
      end else if (cmd.splice) begin
         next_wa = ADDR_W'(prev_rd_ff);
         next_wd = next_rd_ff;
         prev_wa = ADDR_W'(next_rd_ff);
         prev_wd = prev_rd_ff;
      end else if (cmd.detach) begin
         next_wa = ADDR_W'(idx_ff);
         prev_wa = ADDR_W'(idx_ff);
      end else begin
         next_we = 1'b0;
         prev_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.link) begin
         head_in  = idx_ff;
         count_in = count_ff + 1'b1;
      end else if (cmd.splice) begin
         count_in = count_ff - 1'b1;
         if (prev_rd_ff == '0) begin
            head_in = next_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wipe_ff       <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (cmd.wipe) begin
            wipe_ff <= wipe_ff + 1'b1;
         end
         head_ff       <= head_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_status_ff <= cmd.code;
         rsp_count_ff  <= count_in;
         rsp_head_ff   <= head_in;
      end
   end

   // a sole member has both pointers zero, so the head is checked too
   assign flags.idx_ok    = idx_ok_ff;
   assign flags.remove    = remove_ff;
   assign flags.member    = (next_rd_ff != '0) || (prev_rd_ff != '0) || (head_ff == idx_ff);
   assign flags.wipe_last = (wipe_ff == ADDR_W'(NODE_SLOTS - 1));

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_member_count = rsp_count_ff;
   assign rsp_head_index   = rsp_head_ff;

endmodule

`default_nettype wire

// File: hw/rtl/indexed_linked_list_manager_unit.sv
// ---------------------------------------------------------------------------
// indexed_linked_list_manager_unit
// doubly linked list of node indexes with entry zero as sentinel
// ---------------------------------------------------------------------------
// usage:
//   a command word (req_kind, req_node_index) is taken at a rising edge with
//   start high and busy low. req_kind 0 links the node at the head, 1 unlinks
//   it from anywhere in the list.
//   every word gives one result word: rsp_strobe is high for one cycle with
//   rsp_status, rsp_member_count and rsp_head_index valid in that cycle.
//   the receiver cannot stall; there is no backpressure on the result side.
// sequence:
//   the strobe is registered from the check state for inserts and refused
//   words, and from the unlink state after it for a removal. busy drops in
//   the strobe cycle, so the next word can be taken while the result shows.
//   a removal needs the extra state because of the single write port of each
//   pointer store: an unlink needs two writes to each store.
// reset:
//   a synchronous reset empties the list and then runs a clearing pass over
//   all NODE_SLOTS entries of both pointer stores; busy stays high meanwhile.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_linked_list_manager_unit
   import ilm_pkg::*;
#(
   parameter int NODE_SLOTS = DEF_NODE_SLOTS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_kind,
   input  wire logic [FIELD_W-1:0] req_node_index,
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_status,
   output logic [FIELD_W-1:0]      rsp_member_count,
   output logic [FIELD_W-1:0]      rsp_head_index
);

   dp_cmd_type   cmd;
   dp_flags_type flags;

   ilm_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .flags (flags),
      .cmd   (cmd)
   );

   ilm_datapath #(
      .NODE_SLOTS (NODE_SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .flags            (flags),
      .req_kind         (req_kind),
      .req_node_index   (req_node_index),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_member_count (rsp_member_count),
      .rsp_head_index   (rsp_head_index)
   );

endmodule

`default_nettype wire

// File: hw/rtl/ilm_checker.sv
// ---------------------------------------------------------------------------
// ilm_checker
// port-level checks of the indexed linked list manager
// ---------------------------------------------------------------------------
`default_nettype none

`include "indexed_linked_list_manager_unit_macros.svh"

module ilm_port_checker
   import ilm_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               rsp_strobe,
   input wire logic [1:0]         rsp_status,
   input wire logic [FIELD_W-1:0] rsp_member_count,
   input wire logic [FIELD_W-1:0] rsp_head_index
);

   logic accept;
   logic empty_pair;

   assign accept     = start && !busy;
   assign empty_pair = ((rsp_member_count == '0) == (rsp_head_index == '0));

   // clearing pass follows every reset
   `ILM_ASSERT_SAME(a_wipe_after_reset, $past(reset), busy, "not busy after reset")
   `ILM_ASSERT_NEXT(a_busy_after_accept, accept, busy && !rsp_strobe, "accepted word not held")
   `ILM_ASSERT_SAME(a_idle_on_result, rsp_strobe, !busy, "busy while result shown")
   // an empty list has no head and a nonempty one has a head
   `ILM_ASSERT_SAME(a_head_vs_count, rsp_strobe, empty_pair, "head and count disagree")
   // status is always one of the four codes once a result is shown
   `ILM_ASSERT_SAME(a_status_known, rsp_strobe, !$isunknown(rsp_status), "status unknown")

endmodule

bind indexed_linked_list_manager_unit ilm_port_checker u_ilm_checker (.*);

`default_nettype wire
